FILE: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared widths, operation and status codes, and the stored slot entry type
// for the linear-probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int TABLE_DEPTH_DEF = 128;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 31;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 7;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FIND   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DELETED   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd4;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } entry_t;

endpackage

FILE: rtl/lpht_if.sv
// ----------------------------------------------------------------------------
// lpht_in_if / lpht_out_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface lpht_in_if;
  import lpht_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] record_data;

  modport source (output valid, output func, output key, output record_data, input ready);
  modport sink   (input valid, input func, input key, input record_data, output ready);
endinterface

interface lpht_out_if;
  import lpht_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [DATA_W-1:0]   found_data;

  modport source (output valid, output status, output slot, output found_data, input ready);
  modport sink   (input valid, input status, input slot, input found_data, output ready);
endinterface

FILE: rtl/lpht_mem.sv
// ----------------------------------------------------------------------------
// lpht_mem
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpht_mem #(
  parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  lpht_pkg::entry_t    wr_entry,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output lpht_pkg::entry_t    rd_entry
);
  import lpht_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_entry = rd_q_r;

endmodule

FILE: rtl/lpht_home.sv
// ----------------------------------------------------------------------------
// lpht_home
// Home slot unit: key modulo depth. Mask for power-of-two depths, otherwise
// a multiply by a precomputed reciprocal and one correcting subtract, with
// the product and the partial remainder registered before the result.
// ----------------------------------------------------------------------------
module lpht_home #(
  parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lpht_pkg::KEY_W-1:0] key,
  output logic                       done,
  output logic [ADDR_W-1:0]          home
);
  import lpht_pkg::*;

  localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam int SHIFT   = KEY_W + ADDR_W;
  localparam int RECIP_W = 32;
  localparam int PROD_W  = KEY_W + RECIP_W;
  localparam int QUOT_W  = PROD_W - SHIFT;
  localparam int QD_W    = QUOT_W + ADDR_W + 1;
  // floor(2^SHIFT / depth): quotient estimate is exact or one low
  localparam logic [63:0]        RECIP_FULL = (64'd1 << SHIFT) / 64'(TABLE_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP      = RECIP_FULL[RECIP_W-1:0];
  localparam logic [ADDR_W:0]    DEPTH_C    = (ADDR_W+1)'(TABLE_DEPTH);

  logic [KEY_W-1:0]  key_r;
  logic [PROD_W-1:0] prod_r;
  logic [ADDR_W:0]   part_r;
  logic [ADDR_W-1:0] rem_r;
  logic              ph1_r;
  logic              ph2_r;
  logic              done_r;
  logic [QUOT_W-1:0] quot;
  logic [QD_W-1:0]   qd;
  logic [KEY_W-1:0]  diff;

  // partial remainder is below twice the depth
  assign quot = prod_r[PROD_W-1:SHIFT];
  assign qd   = QD_W'(quot) * QD_W'(DEPTH_C);
  assign diff = key_r - qd[KEY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph1_r  <= 1'b0;
      ph2_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      ph1_r  <= start && !IS_POW2;
      ph2_r  <= ph1_r;
      done_r <= (start && IS_POW2) || ph2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_r  <= key;
      prod_r <= PROD_W'(key) * PROD_W'(RECIP);
    end
    if (ph1_r) begin
      part_r <= diff[ADDR_W:0];
    end
    if (start && IS_POW2) begin
      rem_r <= key[ADDR_W-1:0];
    end else if (ph2_r) begin
      rem_r <= (part_r >= DEPTH_C) ? ADDR_W'(part_r - DEPTH_C) : ADDR_W'(part_r);
    end
  end

  assign done = done_r;
  assign home = rem_r;

endmodule

FILE: rtl/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: clearing pass, probe loop over the slot store, write-back and
// the result register.
// ----------------------------------------------------------------------------
module lpht_ctrl #(
  parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  lpht_in_if.sink           in_ch,
  lpht_out_if.source        out_ch,
  output logic              home_start,
  input  logic              home_done,
  input  logic [ADDR_W-1:0] home,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output lpht_pkg::entry_t  wr_entry,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  lpht_pkg::entry_t  rd_entry
);
  import lpht_pkg::*;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HOME  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_BAD   = 3'd4;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_DEPTH - 1);

  logic [2:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [FUNC_W-1:0]   func_r;
  logic [KEY_W-1:0]    key_r;
  logic [DATA_W-1:0]   data_r;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;

  logic in_fire, out_free, valid_op, stop, last, pos_wrap_last;
  logic [ADDR_W-1:0] pos_inc;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign valid_op = (in_ch.func == FN_INSERT) || (in_ch.func == FN_DELETE) ||
                    (in_ch.func == FN_FIND);
  // probe ends on an empty slot, a key match, or once every slot is walked
  assign stop          = !rd_entry.valid || (rd_entry.key == key_r);
  assign last          = (cnt_r == LAST_IDX);
  assign pos_wrap_last = (pos_r == LAST_IDX);
  assign pos_inc       = pos_wrap_last ? '0 : pos_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_data_nxt   = out_data_r;
    home_start     = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_entry       = '{valid: 1'b0, key: rd_entry.key, data: rd_entry.data};
    rd_en          = 1'b0;
    rd_addr        = pos_r;
    in_ch.ready    = 1'b0;

    unique case (state_r)
      S_CLR: begin
        wr_en = 1'b1;
        if (pos_wrap_last) begin
          state_nxt = S_IDLE;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      S_IDLE: begin
        in_ch.ready = 1'b1;
        // ready is high here, so valid alone marks the beat
        if (in_ch.valid) begin
          if (valid_op) begin
            home_start = 1'b1;
            state_nxt  = S_HOME;
          end else begin
            state_nxt  = S_BAD;
          end
        end
      end
      S_HOME: begin
        if (home_done) begin
          rd_en     = 1'b1;
          rd_addr   = home;
          pos_nxt   = home;
          cnt_nxt   = '0;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!stop && !last) begin
          pos_nxt = pos_inc;
          cnt_nxt = cnt_r + 1'b1;
          rd_en   = 1'b1;
          rd_addr = pos_inc;
        end else if (out_free) begin
          // result committed; write-back only now so a stall repeats nothing
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '0;
          out_status_nxt = STAT_NOT_FOUND;
          out_slot_nxt   = '0;
          state_nxt      = S_IDLE;
          if (stop) begin
            out_slot_nxt = SLOT_W'(pos_r);
            priority if (func_r == FN_INSERT) begin
              wr_en          = 1'b1;
              wr_entry       = '{valid: 1'b1, key: key_r, data: data_r};
              out_status_nxt = STAT_INSERTED;
            end else if (rd_entry.valid && func_r == FN_DELETE) begin
              wr_en          = 1'b1;
              out_status_nxt = STAT_DELETED;
            end else if (rd_entry.valid) begin
              out_status_nxt = STAT_FOUND;
              out_data_nxt   = rd_entry.data;
            end else begin
              out_status_nxt = STAT_NOT_FOUND;
            end
          end else if (func_r == FN_INSERT) begin
            out_status_nxt = STAT_FULL;
          end
        end
      end
      S_BAD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_NOT_FOUND;
          out_slot_nxt   = '0;
          out_data_nxt   = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_ch.func;
      key_r  <= in_ch.key;
      data_r <= in_ch.record_data;
    end
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot       = out_slot_r;
  assign out_ch.found_data = out_data_r;

endmodule

FILE: rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing: insert, delete, find.
// ----------------------------------------------------------------------------
// Each input beat carries an operation (insert, delete, find), a 31-bit key
// and a 64-bit data word; each accepted beat yields exactly one result beat
// with status, slot and found data. All slot state lives in one synchronous
// memory of TABLE_DEPTH entries {valid, key, data}. After reset a clearing
// pass writes every entry invalid, one per cycle, so the block takes no
// input until the pass is done. An operation is taken only when the block
// is idle: its home slot is reduced from the key, then its slots (home slot
// plus collisions walked) are probed, before the next beat can be taken.
// For depths that are not a power of two the home-slot reduction takes the
// key modulo the depth by a multiply with a precomputed reciprocal and one
// correcting subtract; a power-of-two depth needs only a mask. The probe
// loop itself runs at one memory read per cycle. A finished result sits in
// an output register, so the next beat is taken while it waits; the loop
// stalls only when a second result is ready before the first has been
// drained. Delete leaves no tombstone: it simply clears the valid bit.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
  parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lpht_in_if.sink     in_ch,
  lpht_out_if.source  out_ch
);
  import lpht_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  // home slot unit handshake
  logic              home_start;
  logic              home_done;
  logic [ADDR_W-1:0] home;

  // slot store ports
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_entry;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_entry;

  lpht_home #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (home_start),
    .key   (in_ch.key),
    .done  (home_done),
    .home  (home)
  );

  lpht_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  lpht_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .home_start (home_start),
    .home_done  (home_done),
    .home       (home),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_entry   (wr_entry),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_entry   (rd_entry)
  );

endmodule
